// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the hold-and-modify decoder, used by hpd_decode.
// Each macro checks one property at the rising clock edge, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/hpd_pkg.sv
// Shared types, constants and functions of the hold-and-modify decoder.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps
`default_nettype none

package hpd_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int PLANES          = 8;
    localparam int PIXELS          = 8;
    localparam int COLOR_W         = 12;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int PIX_CNT_W       = $clog2(PIXELS);
    localparam int PCOUNT_W        = 4;

    localparam logic [PCOUNT_W-1:0] PLANE_COUNT_RESET = 4'd8;

    // Configuration register addresses (word index)
    localparam logic CFG_PLANE_COUNT = 1'b0;

    // Control nibble codes
    localparam logic [3:0] CTRL_PALETTE = 4'd0;
    localparam logic [3:0] CTRL_BLUE    = 4'd1;
    localparam logic [3:0] CTRL_RED     = 4'd2;

    typedef enum logic
    {
        OP_PAL_WRITE = 1'b0,
        OP_DECODE    = 1'b1
    } op_t;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed
    {
        op_t                       op;
        logic [IDX_W-1:0]          palette_index;
        color_t                    palette_color;
        logic                      row_start;
        logic [PLANES-1:0][7:0]    planes;
    } item_t;

    // One decode step: apply the control nibble to the held colour.
    function automatic color_t ham_step(input color_t cur, input logic [7:0] pix,
                                        input color_t pal_col);
        color_t col;
        case (pix[7:4])
            CTRL_PALETTE: col = pal_col;
            CTRL_BLUE:    col = {cur[11:4], pix[3:0]};
            CTRL_RED:     col = {pix[3:0], cur[7:0]};
            default:      col = {cur[11:8], pix[3:0], cur[3:0]};
        endcase
        return col;
    endfunction

    // Byte k carries R bit k as 0x80, G bit k as 0x40, B bit k as 0x30.
    function automatic logic [31:0] pack_color(input color_t c);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++)
        begin
            w[8*k +: 8] = {c[8+k], c[4+k], c[k], c[k], 4'b0000};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hpd_in_stage.sv
// Input register of the hold-and-modify decoder: captures one request.
// Depends on hpd_pkg; absent planes are zeroed at capture.
`timescale 1ns / 1ps
`default_nettype none

module hpd_in_stage
    import hpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire item_t                 in_item,
    input  wire logic [PCOUNT_W-1:0]   plane_count,
    input  wire logic                  consume,
    output logic                       item_valid,
    output item_t                      item
);

    logic  item_valid_reg, item_valid_next;
    item_t item_reg, item_next;

    assign in_stall = item_valid_reg && !consume;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (!in_stall)
        begin
            item_valid_next = in_valid;
        end
        if (in_valid && !in_stall)
        begin
            item_next = in_item;
            // drop planes at or above plane_count
            for (int p = 0; p < PLANES; p++)
            begin
                if (PCOUNT_W'(p) >= plane_count)
                begin
                    item_next.planes[p] = 8'h00;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: rtl/hpd_decode.sv
// Pixel decoder: palette, held colour, pixel counter and result register.
// Depends on hpd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hpd_decode
    import hpd_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire item_t          item,
    output logic                consume,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [COLOR_W-1:0]  rgb,
    output logic [31:0]         packed_high,
    output logic [27:0]         packed_low,
    output logic                last
);

    color_t                      palette_reg [PALETTE_ENTRIES];
    color_t                      held_reg, held_next;
    logic   [PIX_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    color_t                      rgb_reg, rgb_next;
    logic   [31:0]               packed_reg, packed_next;
    logic                        last_reg, last_next;

    logic                        out_free;
    logic                        advance;
    logic                        pal_wr;
    logic   [PIX_CNT_W-1:0]      shift;
    logic   [7:0]                pix;
    color_t                      cur;
    color_t                      col;
    logic                        is_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign pal_wr   = item_valid && (item.op == OP_PAL_WRITE);
    assign advance  = item_valid && (item.op == OP_DECODE) && out_free;
    assign is_last  = (cnt_reg == PIX_CNT_W'(PIXELS - 1));
    assign consume  = pal_wr || (advance && is_last);

    // leftmost pixel sits in bit 7
    assign shift = PIX_CNT_W'(PIXELS - 1) - cnt_reg;

    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            pix[p] = item.planes[p][shift];
        end
    end

    assign cur = (item.row_start && (cnt_reg == '0)) ? palette_reg[0] : held_reg;
    assign col = ham_step(cur, pix, palette_reg[pix[IDX_W-1:0]]);

    always_comb
    begin
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rgb_next       = rgb_reg;
        packed_next    = packed_reg;
        last_next      = last_reg;
        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            held_next      = col;
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
            rgb_next       = col;
            packed_next    = pack_color(col);
            last_next      = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else
        begin
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (pal_wr)
            begin
                palette_reg[item.palette_index] <= item.palette_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg    <= rgb_next;
        packed_reg <= packed_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign rgb         = rgb_reg;
    assign packed_high = packed_reg;
    assign packed_low  = packed_reg[31:4];
    assign last        = last_reg;

    `ASSERT_SAME(a_pal_wr_between_items, clk, rst_n, pal_wr, cnt_reg == '0)
    `ASSERT_NEXT(a_last_on_final_pixel, clk, rst_n, advance && is_last, last_reg && out_valid_reg)
    `ASSERT_SAME(a_rise_needs_advance, clk, rst_n, $rose(out_valid_reg), $past(advance))

endmodule

`default_nettype wire

// File: rtl/planar_ham_pixel_decoder.sv
// Hold-and-modify planar pixel decoder. A palette-write request returns
// nothing. A decode request returns eight pixel results, leftmost first, one
// per cycle while out_stall is low, via the single result register fed by the
// pixel counter. The input register takes the next request once the last pixel
// of the current one is registered, even while it waits downstream. The 16-entry
// palette sits in flip-flops cleared at reset, so there is no clearing pass.
// plane_count lives at byte address 0 of the APB port; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module planar_ham_pixel_decoder
    import hpd_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,

    // APB configuration port
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // request channel
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           op,
    input  wire logic [3:0]     palette_index,
    input  wire logic [11:0]    palette_color,
    input  wire logic           row_start,
    input  wire logic [7:0]     plane0_byte,
    input  wire logic [7:0]     plane1_byte,
    input  wire logic [7:0]     plane2_byte,
    input  wire logic [7:0]     plane3_byte,
    input  wire logic [7:0]     plane4_byte,
    input  wire logic [7:0]     plane5_byte,
    input  wire logic [7:0]     plane6_byte,
    input  wire logic [7:0]     plane7_byte,

    // result channel
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [11:0]         rgb,
    output logic [31:0]         packed_high,
    output logic [27:0]         packed_low,
    output logic                last
);

    logic [PCOUNT_W-1:0] plane_count_reg, plane_count_next;
    logic                cfg_wr;
    item_t               in_item;
    item_t               item;
    logic                item_valid;
    logic                consume;

    // Configuration: one register, word-addressed by paddr[2].
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_PLANE_COUNT);

    always_comb
    begin
        plane_count_next = plane_count_reg;
        if (cfg_wr)
        begin
            plane_count_next = pwdata[PCOUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= PLANE_COUNT_RESET;
        end
        else
        begin
            plane_count_reg <= plane_count_next;
        end
    end

    // Read back plane_count; holes read as zero.
    assign prdata = (paddr[2] == CFG_PLANE_COUNT) ? {28'd0, plane_count_reg} : 32'd0;

    // Gather the request fields; plane k supplies bit k of each pixel.
    always_comb
    begin
        in_item.op            = op_t'(op);
        in_item.palette_index = palette_index;
        in_item.palette_color = palette_color;
        in_item.row_start     = row_start;
        in_item.planes[0]     = plane0_byte;
        in_item.planes[1]     = plane1_byte;
        in_item.planes[2]     = plane2_byte;
        in_item.planes[3]     = plane3_byte;
        in_item.planes[4]     = plane4_byte;
        in_item.planes[5]     = plane5_byte;
        in_item.planes[6]     = plane6_byte;
        in_item.planes[7]     = plane7_byte;
    end

    // Hold one request; advance when the decoder retires it.
    hpd_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .plane_count (plane_count_reg),
        .consume     (consume),
        .item_valid  (item_valid),
        .item        (item)
    );

    // Emit one pixel per cycle from the held request into the result register unless out_stall holds it.
    hpd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .consume     (consume),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rgb         (rgb),
        .packed_high (packed_high),
        .packed_low  (packed_low),
        .last        (last)
    );

endmodule

`default_nettype wire
